### rtl/row_pixel_resampler_macros.svh
// assertion macros for the row pixel resampler
`ifndef ROW_PIXEL_RESAMPLER_MACROS_SVH
`define ROW_PIXEL_RESAMPLER_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define RPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("row_pixel_resampler assertion failed");
// same-cycle implication
`define RPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("row_pixel_resampler implication failed");
// next-cycle implication
`define RPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("row_pixel_resampler sequence failed");
`else
`define RPR_ASSERT(lbl, prop)
`define RPR_ASSERT_IMPL(lbl, ante, cons)
`define RPR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/rpr_pkg.sv
// shared constants and types of the row pixel resampler
`default_nettype none

package rpr_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 4;
  localparam int unsigned PixW    = ChanW * NumChan;
  localparam int unsigned FracW   = 32;
  localparam int unsigned PosW    = 45;
  localparam int unsigned StepW   = 44;
  localparam int unsigned WidthW  = 13;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned DefMaxWidth = 4096;
  localparam int unsigned DefMaxRun   = 64;

  localparam logic [PosW-1:0]   PosOne   = 45'h0_0001_0000_0000;
  localparam logic              ModeRst  = 1'b1;
  localparam logic [StepW-1:0]  StepRst  = 44'h001_0000_0000;
  localparam logic [WidthW-1:0] WidthRst = 13'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE  = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_WIDTH = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // control from the sequencer to the output stage
  typedef struct packed {
    logic load;
    logic linear;
    logic run_last;
    logic row_last;
  } emit_t;

endpackage

`default_nettype wire

### rtl/rpr_lane.sv
// one channel lane: linear blend of two bytes by a 32-bit fraction
`default_nettype none

module rpr_lane (
  input  logic [rpr_pkg::ChanW-1:0] left_i,
  input  logic [rpr_pkg::ChanW-1:0] right_i,
  input  logic [rpr_pkg::FracW-1:0] frac_i,
  output logic [rpr_pkg::ChanW-1:0] blend_o
);
  import rpr_pkg::*;

  logic signed [ChanW:0]         diff;
  logic signed [FracW:0]         frac_s;
  logic signed [ChanW+FracW+1:0] prod;

  assign diff   = $signed({1'b0, right_i}) - $signed({1'b0, left_i});
  assign frac_s = $signed({1'b0, frac_i});
  assign prod   = diff * frac_s;
  // arithmetic shift right by the fraction width, wrapped to one byte
  assign blend_o = left_i + prod[FracW+ChanW-1:FracW];

endmodule

`default_nettype wire

### rtl/rpr_merge.sv
// output stage: registers the lane results or the nearest source pixel as one output pixel
`default_nettype none

module rpr_merge (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  rpr_pkg::emit_t                               emit_i,
  input  logic [rpr_pkg::NumChan-1:0][rpr_pkg::ChanW-1:0] lane_i,
  input  logic [rpr_pkg::NumChan-1:0][rpr_pkg::ChanW-1:0] near_i,
  output logic                                         slot_free_o,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [rpr_pkg::ChanW-1:0]                    out0_o,
  output logic [rpr_pkg::ChanW-1:0]                    out1_o,
  output logic [rpr_pkg::ChanW-1:0]                    out2_o,
  output logic [rpr_pkg::ChanW-1:0]                    out3_o,
  output logic                                         run_last_o,
  output logic                                         row_last_o
);
  import rpr_pkg::*;

  logic                            valid_q, valid_d;
  logic [NumChan-1:0][ChanW-1:0]   pix_q, pix_d;
  logic                            run_last_q, run_last_d;
  logic                            row_last_q, row_last_d;

  assign slot_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d    = valid_q;
    pix_d      = pix_q;
    run_last_d = run_last_q;
    row_last_d = row_last_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (emit_i.load) begin
      valid_d    = 1'b1;
      pix_d      = emit_i.linear ? lane_i : near_i;
      run_last_d = emit_i.run_last;
      row_last_d = emit_i.row_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    run_last_q <= run_last_d;
    row_last_q <= row_last_d;
  end

  assign out_valid_o = valid_q;
  assign out0_o      = pix_q[0];
  assign out1_o      = pix_q[1];
  assign out2_o      = pix_q[2];
  assign out3_o      = pix_q[3];
  assign run_last_o  = run_last_q;
  assign row_last_o  = row_last_q;

endmodule

`default_nettype wire

### rtl/row_pixel_resampler.sv
// row pixel resampler top level: config registers, run sequencer, lanes, output stage
`default_nettype none
`include "row_pixel_resampler_macros.svh"

// Horizontal resampler for one image row of four-byte pixels. A source pixel
// transaction is taken while the sequencer is idle; the sequencer then issues
// one output pixel per cycle, while its single output register has room, and
// ends each run with a closing step, which is all that a pixel dropped by
// downscaling gets. At the row end, when outputs are still missing, each whole
// unit of position consumed without an output takes a step of its own. Four
// channel lanes blend in parallel, each with one 9x33-bit multiply. The config
// port is always ready; write it only while the block is idle. Output widths
// above MAX_WIDTH are clamped; at most MAX_RUN outputs follow one source pixel.

module row_pixel_resampler #(
  parameter int unsigned MAX_WIDTH = rpr_pkg::DefMaxWidth,
  parameter int unsigned MAX_RUN   = rpr_pkg::DefMaxRun
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rpr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpr_pkg::StepW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rpr_pkg::ChanW-1:0]    chan0_i,
  input  logic [rpr_pkg::ChanW-1:0]    chan1_i,
  input  logic [rpr_pkg::ChanW-1:0]    chan2_i,
  input  logic [rpr_pkg::ChanW-1:0]    chan3_i,
  input  logic                         row_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rpr_pkg::ChanW-1:0]    out0_o,
  output logic [rpr_pkg::ChanW-1:0]    out1_o,
  output logic [rpr_pkg::ChanW-1:0]    out2_o,
  output logic [rpr_pkg::ChanW-1:0]    out3_o,
  output logic                         run_last_o,
  output logic                         row_last_o
);
  import rpr_pkg::*;

  localparam int unsigned WidthCap = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int unsigned RunW     = $clog2(MAX_RUN + 1);

  // configuration registers
  logic               mode_q, mode_d;
  logic [StepW-1:0]   step_q, step_d;
  logic [WidthW-1:0]  ow_q, ow_d;

  // row state
  state_e             state_q, state_d;
  logic [1:0]         seen_q, seen_d;
  logic [PixW-1:0]    left_q, left_d;
  logic [PixW-1:0]    right_q, right_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [WidthW-1:0]  done_q, done_d;
  logic [RunW-1:0]    cnt_q, cnt_d;
  logic               end_q, end_d;

  logic               accept;
  logic [PixW-1:0]    src_pix;
  logic [1:0]         seen_inc;
  logic               active;
  logic [WidthW-1:0]  width_eff;
  logic               can_go;
  logic               slot_free;
  logic               emit_fire;
  logic               skip;
  logic               finish;
  logic [PosW-1:0]    pos_add;
  logic [PosW-1:0]    pos_fin;
  logic [RunW-1:0]    cnt_inc;
  logic [WidthW-1:0]  done_inc;
  logic               more;
  emit_t              emit;

  logic [NumChan-1:0][ChanW-1:0] lane_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign src_pix     = {chan3_i, chan2_i, chan1_i, chan0_i};
  assign seen_inc    = (seen_q == 2'd2) ? 2'd2 : seen_q + 2'd1;
  assign active      = !mode_q || seen_inc[1] || row_end_i;

  assign width_eff = (ow_q > WidthW'(WidthCap)) ? WidthW'(WidthCap) : ow_q;
  assign can_go    = (pos_q < PosOne) && (done_q < width_eff) && (cnt_q < RunW'(MAX_RUN));
  assign emit_fire = (state_q == ST_RUN) && can_go && slot_free;
  // past the row end: consume one unit of position using the last pixel twice
  assign skip      = (state_q == ST_RUN) && !can_go && end_q &&
                     (done_q < width_eff) && (cnt_q < RunW'(MAX_RUN));
  assign finish    = (state_q == ST_RUN) && !can_go && !skip;

  assign pos_add  = pos_q + {1'b0, step_q};
  assign pos_fin  = (pos_q >= PosOne) ? pos_q - PosOne : pos_q;
  assign cnt_inc  = cnt_q + RunW'(1);
  assign done_inc = done_q + WidthW'(1);
  // another output follows in this run
  assign more = (cnt_inc < RunW'(MAX_RUN)) && (done_inc < width_eff) &&
                ((pos_add < PosOne) || end_q);

  assign emit.load     = emit_fire;
  assign emit.linear   = mode_q;
  assign emit.run_last = !more;
  assign emit.row_last = (done_inc == width_eff);

  // configuration decode
  always_comb begin
    mode_d = mode_q;
    step_d = step_q;
    ow_d   = ow_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:  mode_d = cfg_data_i[0];
        CFG_STEP:  step_d = cfg_data_i;
        CFG_WIDTH: ow_d   = cfg_data_i[WidthW-1:0];
        default:   ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && active) state_d = ST_RUN;
      ST_RUN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    seen_d  = seen_q;
    left_d  = left_q;
    right_d = right_q;
    pos_d   = pos_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    if (accept) begin
      left_d  = (seen_q == 2'd0) ? src_pix : right_q;
      right_d = src_pix;
      seen_d  = seen_inc;
      cnt_d   = '0;
      end_d   = row_end_i;
    end
    if (emit_fire) begin
      pos_d  = pos_add;
      done_d = done_inc;
      cnt_d  = cnt_inc;
    end
    if (skip) begin
      pos_d  = pos_q - PosOne;
      left_d = right_q;
    end
    if (finish) begin
      pos_d = pos_fin;
      if (end_q) begin
        pos_d  = '0;
        done_d = '0;
        seen_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeRst;
      step_q  <= StepRst;
      ow_q    <= WidthRst;
      state_q <= ST_IDLE;
      seen_q  <= 2'd0;
      left_q  <= '0;
      right_q <= '0;
      pos_q   <= '0;
      done_q  <= '0;
      cnt_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      step_q  <= step_d;
      ow_q    <= ow_d;
      state_q <= state_d;
      seen_q  <= seen_d;
      left_q  <= left_d;
      right_q <= right_d;
      pos_q   <= pos_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
    end
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    rpr_lane u_lane (
      .left_i  (left_q[c*ChanW +: ChanW]),
      .right_i (right_q[c*ChanW +: ChanW]),
      .frac_i  (pos_q[FracW-1:0]),
      .blend_o (lane_res[c])
    );
  end

  rpr_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .lane_i      (lane_res),
    .near_i      (right_q),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out0_o      (out0_o),
    .out1_o      (out1_o),
    .out2_o      (out2_o),
    .out3_o      (out3_o),
    .run_last_o  (run_last_o),
    .row_last_o  (row_last_o)
  );

  `RPR_ASSERT_IMPL(a_row_last_ends_run, emit.load && emit.row_last, emit.run_last)
  `RPR_ASSERT(a_done_in_range, done_q <= WidthW'(WidthCap))
  `RPR_ASSERT(a_run_in_range, cnt_q <= RunW'(MAX_RUN))
  `RPR_ASSERT_IMPL(a_fresh_row_clear, state_q == ST_IDLE && seen_q == 2'd0,
                   done_q == '0 && pos_q == '0)
  `RPR_ASSERT_NEXT(a_finish_idles, finish, in_ready_o)

endmodule

`default_nettype wire
